FILE: rtl/gfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfn_pkg: shared widths for the base-10 divisor test unit
// Field widths of the candidate, result and exponent register.
// ----------------------------------------------------------------------------
package gfn_pkg;
    localparam int unsigned K_W   = 63;
    localparam int unsigned P_W   = 64;
    localparam int unsigned EXP_W = 6;
    localparam logic [EXP_W-1:0] EXP_RESET = 6'd20;
endpackage

FILE: rtl/gfn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfn interfaces: valid/ready channels of the divisor test unit
// Candidate input, result output and exponent write channels.
// ----------------------------------------------------------------------------
interface gfn_in_if;
    logic                      valid;
    logic                      ready;
    logic [gfn_pkg::K_W-1:0]   candidate_k;
    modport source (output valid, output candidate_k, input ready);
    modport sink   (input valid, input candidate_k, output ready);
endinterface

interface gfn_out_if;
    logic                      valid;
    logic                      ready;
    logic [gfn_pkg::P_W-1:0]   prime_candidate;
    logic                      is_divisor;
    logic                      out_of_range;
    modport source (output valid, output prime_candidate, output is_divisor,
                    output out_of_range, input ready);
    modport sink   (input valid, input prime_candidate, input is_divisor,
                    input out_of_range, output ready);
endinterface

interface gfn_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [gfn_pkg::EXP_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/gfn_base10_divisor_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfn_base10_divisor_test_unit: base-10 generalized Fermat divisor test
// Forms p = k*2^(n+1)+1 and checks 10^(2^n) == -1 mod p by repeated squaring.
// ----------------------------------------------------------------------------
//  channel     dir   beat contents
//  i_cand      in    candidate_k
//  o_res       out   prime_candidate, is_divisor, out_of_range
//  i_cfg       in    exponent (data)
//
//  Each squaring is a shift-add modular multiply, one bit of the multiplier
//  per cycle through one shared doubling/add-mod unit, after a setup step
//  (S_NEXT) per squaring. Out-of-range candidates get their result straight
//  from idle, with no test run.
//  The block takes no candidate while one is in work or its result waits.
//  Reset (synchronous, active low) restores exponent 20 and goes idle.
module gfn_base10_divisor_test_unit #(
    parameter int unsigned WORD_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gfn_in_if.sink    i_cand,
    gfn_out_if.source o_res,
    gfn_cfg_if.sink   i_cfg
);
    import gfn_pkg::*;

    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned BW = $clog2(W);

    typedef enum logic [2:0] {S_IDLE, S_INIT, S_BIT, S_NEXT, S_DONE} t_state;

    t_state           r_state;
    logic [EXP_W-1:0] r_exp;
    logic [EXP_W-1:0] r_cnt;
    logic [W-1:0]     r_p;
    logic [W-1:0]     r_x;
    logic [W-1:0]     r_acc;
    logic [BW-1:0]    r_bit;
    logic [P_W-1:0]   r_res_p;
    logic             r_res_div;
    logic             r_res_oor;
    logic             r_res_valid;

    // fit check and candidate forming
    logic [EXP_W:0]  w_n1;
    logic            w_fits;
    logic [W-1:0]    w_p;
    logic [K_W-1:0]  w_k;
    logic [P_W:0]    w_kwide;
    always_comb begin
        w_k     = i_cand.candidate_k;
        w_n1    = {1'b0, r_exp} + 7'd1;
        w_kwide = {2'b00, w_k};
        if (w_n1 >= (EXP_W+1)'(W))
            w_fits = (w_k == '0);
        else
            w_fits = ((w_kwide >> ((EXP_W+1)'(W) - w_n1)) == '0);
        if (w_k == '0)
            w_p = W'(1);
        else
            w_p = W'(w_kwide << w_n1) + W'(1);
    end

    // shared add-mod unit: doubling then conditional add of x
    logic [W:0]   w_s1, w_s2;
    logic [W-1:0] w_d, w_a;
    always_comb begin
        w_s1 = {1'b0, r_acc} + {1'b0, r_acc};
        w_d  = (w_s1 >= {1'b0, r_p}) ? W'(w_s1 - {1'b0, r_p}) : w_s1[W-1:0];
        w_s2 = {1'b0, w_d} + {1'b0, r_x};
        w_a  = (w_s2 >= {1'b0, r_p}) ? W'(w_s2 - {1'b0, r_p}) : w_s2[W-1:0];
    end

    assign i_cand.ready = (r_state == S_IDLE) && !r_res_valid;
    assign i_cfg.ready  = 1'b1;
    assign o_res.valid           = r_res_valid;
    assign o_res.prime_candidate = r_res_p;
    assign o_res.is_divisor      = r_res_div;
    assign o_res.out_of_range    = r_res_oor;

    // load a result beat this cycle
    logic w_res_load;
    assign w_res_load = ((r_state == S_IDLE) && i_cand.valid && i_cand.ready && !w_fits)
                     || ((r_state == S_DONE) && (!r_res_valid || o_res.ready));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= EXP_RESET;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_exp <= i_cfg.data;
            end
            // hold the result beat until taken
            if (w_res_load) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cand.valid && i_cand.ready) begin
                        if (!w_fits) begin
                            r_res_p     <= '0;
                            r_res_div   <= 1'b0;
                            r_res_oor   <= 1'b1;
                        end else begin
                            r_p     <= w_p;
                            r_cnt   <= r_exp;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    // 10 mod p with p odd or 1: picked from a table of the small p values
                    if (r_p == W'(1))      r_x <= '0;
                    else if (r_p == W'(3)) r_x <= W'(1);
                    else if (r_p == W'(5)) r_x <= '0;
                    else if (r_p == W'(9)) r_x <= W'(1);
                    else if (r_p == W'(7)) r_x <= W'(3);
                    else                   r_x <= W'(10);
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_acc   <= '0;
                        r_bit   <= BW'(W-1);
                        r_state <= S_BIT;
                    end
                end
                S_BIT: begin
                    // one multiplier bit per cycle
                    r_acc <= r_x[r_bit] ? w_a : w_d;
                    if (r_bit == '0) begin
                        r_state <= S_NEXT;
                        r_x     <= r_x[r_bit] ? w_a : w_d;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_res_valid || o_res.ready) begin
                        r_res_p     <= P_W'(r_p);
                        r_res_div   <= (r_x == r_p - W'(1));
                        r_res_oor   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
